// File: rtl/rpt_pkg.sv
// ---------------------------------------------------------------------------
// Revolved primitive tessellator package
// Shared constants, types and helper functions for the tessellator.
// ---------------------------------------------------------------------------
`default_nettype none

package rpt_pkg;

    localparam int ANGLE_BITS       = 16;
    localparam int TABLE_ENTRIES    = 1024;
    localparam int MAX_SUBDIVISIONS = 360;

    localparam int COORD_W = 27;
    localparam int Q16_W   = 18;
    localparam int RAD_W   = 24;
    localparam int IDX_W   = 9;
    localparam int STEP_W  = 16;
    localparam int CNT_W   = 9;

    localparam logic [RAD_W-1:0] MIN_OUTER  = 24'd655;
    localparam logic [RAD_W-1:0] MIN_INNER  = 24'd328;
    localparam logic [RAD_W-1:0] MIN_HEIGHT = 24'd655;
    localparam logic [CNT_W-1:0] MIN_COUNT  = 9'd3;

    // register indexes (word address)
    localparam logic [2:0] REG_SHAPE      = 3'd0;
    localparam logic [2:0] REG_OUTER      = 3'd1;
    localparam logic [2:0] REG_INNER      = 3'd2;
    localparam logic [2:0] REG_HEIGHT     = 3'd3;
    localparam logic [2:0] REG_SEG_COUNT  = 3'd4;
    localparam logic [2:0] REG_RING_COUNT = 3'd5;
    localparam logic [2:0] REG_SEG_STEP   = 3'd6;
    localparam logic [2:0] REG_RING_STEP  = 3'd7;

    typedef enum logic [1:0] {
        SHAPE_CONE  = 2'd0,
        SHAPE_CYL   = 2'd1,
        SHAPE_TUBE  = 2'd2,
        SHAPE_TORUS = 2'd3
    } t_shape;

    typedef enum logic [1:0] {
        RSEL_ZERO  = 2'd0,
        RSEL_OUTER = 2'd1,
        RSEL_INNER = 2'd2,
        RSEL_TUBE  = 2'd3
    } t_rsel;

    typedef struct packed {
        logic  seg_next;
        logic  ring_next;
        t_rsel rsel;
        logic  y_top;
    } t_point;

    // one vertex request into the compute pipeline
    typedef struct packed {
        logic             torus;
        logic             last;
        logic [IDX_W-1:0] seg_idx;
        logic [IDX_W-1:0] ring_idx;
        logic [RAD_W-1:0] rad;
        logic [RAD_W-1:0] outer;
        logic [RAD_W-1:0] yv;
    } t_vtx_req;

    // last quad/triangle group index of a slice
    function automatic logic [2:0] last_group(input t_shape mode);
        logic [2:0] g;
        case (mode)
            SHAPE_CYL:  g = 3'd2;
            SHAPE_TUBE: g = 3'd7;
            default:    g = 3'd0;
        endcase
        return g;
    endfunction

    // which point a slice position refers to; groups are six vertices long
    function automatic t_point point_desc(input t_shape mode, input logic [2:0] grp,
                                          input logic [2:0] pos);
        logic [1:0] c;
        logic [2:0] tg;
        logic [1:0] sx;
        logic [1:0] sy;
        logic [1:0] s;
        t_point     p;
        // quad A,B,C,D emitted as A,B,C,C,B,D
        case (pos)
            3'd0:    c = 2'd0;
            3'd1:    c = 2'd1;
            3'd2:    c = 2'd2;
            3'd3:    c = 2'd2;
            3'd4:    c = 2'd1;
            default: c = 2'd3;
        endcase
        // surface pairs {inner, top}; cylinder reuses the outer pairs
        tg = grp;
        if (mode == SHAPE_CYL) begin
            tg = (grp == 3'd0) ? 3'd5 : 3'd4;
        end
        case (tg)
            3'd0:    begin sx = 2'b00; sy = 2'b10; end
            3'd1:    begin sx = 2'b10; sy = 2'b00; end
            3'd2:    begin sx = 2'b01; sy = 2'b11; end
            3'd3:    begin sx = 2'b11; sy = 2'b01; end
            3'd4:    begin sx = 2'b00; sy = 2'b01; end
            3'd5:    begin sx = 2'b01; sy = 2'b00; end
            3'd6:    begin sx = 2'b10; sy = 2'b11; end
            default: begin sx = 2'b11; sy = 2'b10; end
        endcase
        s           = c[1] ? sy : sx;
        p.seg_next  = c[0];
        p.ring_next = 1'b0;
        p.rsel      = s[1] ? RSEL_INNER : RSEL_OUTER;
        p.y_top     = s[0];
        if (mode == SHAPE_TORUS) begin
            p.seg_next  = c[1];
            p.ring_next = c[0];
            p.rsel      = RSEL_TUBE;
            p.y_top     = 1'b0;
        end else if (mode == SHAPE_CONE || (mode == SHAPE_CYL && grp == 3'd2)) begin
            // apex/centre triangles
            case (pos)
                3'd0:    p = '{1'b0, 1'b0, RSEL_ZERO, 1'b0};
                3'd1:    p = '{1'b0, 1'b0, RSEL_OUTER, 1'b0};
                3'd2:    p = '{1'b1, 1'b0, RSEL_OUTER, 1'b0};
                3'd3:    p = '{1'b0, 1'b0, RSEL_ZERO, 1'b1};
                3'd4:    p = '{1'b1, 1'b0, RSEL_OUTER, (mode == SHAPE_CYL)};
                default: p = '{1'b0, 1'b0, RSEL_OUTER, (mode == SHAPE_CYL)};
            endcase
        end
        return p;
    endfunction

    // clamp a subdivision count to 3..max
    function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] c,
                                                     input int max_c);
        logic [CNT_W-1:0] r;
        if (c < MIN_COUNT) begin
            r = MIN_COUNT;
        end else if (int'(c) > max_c) begin
            r = CNT_W'(max_c);
        end else begin
            r = c;
        end
        return r;
    endfunction

    // quarter-wave sine of entry j of a table of 2^lg entries, Q16
    function automatic logic [16:0] sine_quarter(input int unsigned j, input int unsigned lg);
        longint unsigned r;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned s;
        longint unsigned v;
        r  = longint'(j) << (32 - lg);
        x  = (r * 64'd1686629713) >> 30;
        x2 = (x * x) >> 30;
        s  = 64'd1073741824;
        s  = 64'd1073741824 - ((x2 * s) >> 30) / 110;
        s  = 64'd1073741824 - ((x2 * s) >> 30) / 72;
        s  = 64'd1073741824 - ((x2 * s) >> 30) / 42;
        s  = 64'd1073741824 - ((x2 * s) >> 30) / 20;
        s  = 64'd1073741824 - ((x2 * s) >> 30) / 6;
        v  = (x * s) >> 30;
        return 17'((v + 64'd8192) >> 14);
    endfunction

    // Q16 product rounded half away from zero
    function automatic logic signed [COORD_W-1:0] mul_q16(input logic signed [Q16_W-1:0] a,
                                                          input logic signed [COORD_W-1:0] b);
        logic signed [Q16_W+COORD_W-1:0] p;
        logic [Q16_W+COORD_W-1:0]        mag;
        logic [Q16_W+COORD_W-1:0]        rnd;
        p   = a * b;
        mag = p[Q16_W+COORD_W-1] ? $unsigned(-p) : $unsigned(p);
        rnd = (mag + (Q16_W+COORD_W)'(32768)) >> 16;
        return p[Q16_W+COORD_W-1] ? -$signed(rnd[COORD_W-1:0]) : $signed(rnd[COORD_W-1:0]);
    endfunction

endpackage

`default_nettype wire

// File: rtl/rpt_if.sv
// ---------------------------------------------------------------------------
// Tessellator stream interfaces
// Request channel (slice indices) and result channel (vertices).
// ---------------------------------------------------------------------------
`default_nettype none

interface rpt_in_if;
    logic       valid;
    logic       ready;
    logic [8:0] segment_index;
    logic [8:0] ring_index;

    modport source (output valid, output segment_index, output ring_index, input ready);
    modport sink   (input valid, input segment_index, input ring_index, output ready);
endinterface

interface rpt_out_if;
    logic               valid;
    logic               ready;
    logic signed [26:0] vertex_x;
    logic signed [26:0] vertex_y;
    logic signed [26:0] vertex_z;
    logic               last_vertex;

    modport source (output valid, output vertex_x, output vertex_y, output vertex_z,
                    output last_vertex, input ready);
    modport sink   (input valid, input vertex_x, input vertex_y, input vertex_z,
                    input last_vertex, output ready);
endinterface

`default_nettype wire

// File: rtl/rpt_vertex_pipe.sv
// ---------------------------------------------------------------------------
// Tessellator vertex pipeline
// Five register stages: phase, sine table, radius product, torus sum,
// ring product. One vertex per cycle; the whole pipe holds on a stall.
// ---------------------------------------------------------------------------
`default_nettype none

module rpt_vertex_pipe #(
    parameter int ANGLE_BITS    = rpt_pkg::ANGLE_BITS,
    parameter int TABLE_ENTRIES = rpt_pkg::TABLE_ENTRIES
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_req_valid,
    input  wire rpt_pkg::t_vtx_req             i_req,
    input  wire logic [rpt_pkg::STEP_W-1:0]    i_seg_step,
    input  wire logic [rpt_pkg::STEP_W-1:0]    i_ring_step,
    output logic                               o_req_ready,
    input  wire logic                          i_out_ready,
    output logic                               o_out_valid,
    output logic signed [rpt_pkg::COORD_W-1:0] o_x,
    output logic signed [rpt_pkg::COORD_W-1:0] o_y,
    output logic signed [rpt_pkg::COORD_W-1:0] o_z,
    output logic                               o_last
);

    localparam int L    = $clog2(TABLE_ENTRIES);
    localparam int QTR  = TABLE_ENTRIES / 4;
    localparam int PW   = rpt_pkg::IDX_W + rpt_pkg::STEP_W;
    localparam int CW   = rpt_pkg::COORD_W;
    localparam int QW   = rpt_pkg::Q16_W;
    localparam int RW   = rpt_pkg::RAD_W;

    logic en;

    // quarter-wave sine table, constant logic
    logic [16:0] qtab [QTR+1];
    for (genvar g = 0; g <= QTR; g++) begin : g_qtab
        assign qtab[g] = rpt_pkg::sine_quarter(g, L);
    end

    // whole pipe advances while the output stage is free or drained
    assign en          = !o_out_valid || i_out_ready;
    assign o_req_ready = en;

    // ---- stage B: phase to table index
    logic [PW-1:0]            prod_a;
    logic [PW-1:0]            prod_b;
    logic [ANGLE_BITS+PW-1:0] ext_a;
    logic [ANGLE_BITS+PW-1:0] ext_b;
    logic [ANGLE_BITS+L-1:0]  sh_a;
    logic [ANGLE_BITS+L-1:0]  sh_b;

    logic          r_b_vld;
    logic          r_b_torus;
    logic          r_b_last;
    logic [RW-1:0] r_b_rad;
    logic [RW-1:0] r_b_outer;
    logic [RW-1:0] r_b_yv;
    logic [L-1:0]  r_b_ka;
    logic [L-1:0]  r_b_kb;

    always_comb begin
        prod_a = PW'(i_req.seg_idx) * PW'(i_seg_step);
        prod_b = PW'(i_req.ring_idx) * PW'(i_ring_step);
        ext_a  = (ANGLE_BITS+PW)'(prod_a);
        ext_b  = (ANGLE_BITS+PW)'(prod_b);
        sh_a   = {ext_a[ANGLE_BITS-1:0], {L{1'b0}}};
        sh_b   = {ext_b[ANGLE_BITS-1:0], {L{1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (en) begin
            r_b_vld <= i_req_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_torus <= i_req.torus;
            r_b_last  <= i_req.last;
            r_b_rad   <= i_req.rad;
            r_b_outer <= i_req.outer;
            r_b_yv    <= i_req.yv;
            r_b_ka    <= sh_a[ANGLE_BITS+L-1:ANGLE_BITS];
            r_b_kb    <= sh_b[ANGLE_BITS+L-1:ANGLE_BITS];
        end
    end

    // ---- stage C: sine/cosine lookups (sin a, cos a, sin b, cos b)
    logic [L-1:0]          kk   [4];
    logic [1:0]            qd   [4];
    logic [L-2:0]          tidx [4];
    logic signed [QW-1:0]  trg  [4];

    logic                  r_c_vld;
    logic                  r_c_torus;
    logic                  r_c_last;
    logic [RW-1:0]         r_c_rad;
    logic [RW-1:0]         r_c_outer;
    logic [RW-1:0]         r_c_yv;
    logic signed [QW-1:0]  r_c_trg [4];

    always_comb begin
        kk[0] = r_b_ka;
        kk[1] = r_b_ka + L'(QTR);
        kk[2] = r_b_kb;
        kk[3] = r_b_kb + L'(QTR);
        for (int i = 0; i < 4; i++) begin
            qd[i]   = kk[i][L-1:L-2];
            tidx[i] = qd[i][0] ? ((L-1)'(QTR) - {1'b0, kk[i][L-3:0]})
                               : {1'b0, kk[i][L-3:0]};
            trg[i]  = qd[i][1] ? -$signed({1'b0, qtab[tidx[i]]})
                               : $signed({1'b0, qtab[tidx[i]]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (en) begin
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_torus <= r_b_torus;
            r_c_last  <= r_b_last;
            r_c_rad   <= r_b_rad;
            r_c_outer <= r_b_outer;
            r_c_yv    <= r_b_yv;
            for (int i = 0; i < 4; i++) begin
                r_c_trg[i] <= trg[i];
            end
        end
    end

    // ---- stage D: segment trig times radius
    logic                 r_d_vld;
    logic                 r_d_torus;
    logic                 r_d_last;
    logic [RW-1:0]        r_d_outer;
    logic [RW-1:0]        r_d_yv;
    logic signed [CW-1:0] r_d_car;
    logic signed [CW-1:0] r_d_sar;
    logic signed [QW-1:0] r_d_sb;
    logic signed [QW-1:0] r_d_cb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else if (en) begin
            r_d_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_torus <= r_c_torus;
            r_d_last  <= r_c_last;
            r_d_outer <= r_c_outer;
            r_d_yv    <= r_c_yv;
            r_d_car   <= rpt_pkg::mul_q16(r_c_trg[1], $signed(CW'(r_c_rad)));
            r_d_sar   <= rpt_pkg::mul_q16(r_c_trg[0], $signed(CW'(r_c_rad)));
            r_d_sb    <= r_c_trg[2];
            r_d_cb    <= r_c_trg[3];
        end
    end

    // ---- stage E: torus centre distance
    logic                 r_e_vld;
    logic                 r_e_torus;
    logic                 r_e_last;
    logic [RW-1:0]        r_e_yv;
    logic signed [CW-1:0] r_e_car;
    logic signed [CW-1:0] r_e_sar;
    logic signed [CW-1:0] r_e_big;
    logic signed [QW-1:0] r_e_sb;
    logic signed [QW-1:0] r_e_cb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else if (en) begin
            r_e_vld <= r_d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e_torus <= r_d_torus;
            r_e_last  <= r_d_last;
            r_e_yv    <= r_d_yv;
            r_e_car   <= r_d_car;
            r_e_sar   <= r_d_sar;
            r_e_big   <= $signed(CW'(r_d_outer)) + r_d_car;
            r_e_sb    <= r_d_sb;
            r_e_cb    <= r_d_cb;
        end
    end

    // ---- stage F: ring products and output register
    logic signed [CW-1:0] n_x;
    logic signed [CW-1:0] n_y;
    logic signed [CW-1:0] n_z;

    always_comb begin
        if (r_e_torus) begin
            n_x = rpt_pkg::mul_q16(r_e_cb, r_e_big);
            n_y = r_e_sar;
            n_z = -rpt_pkg::mul_q16(r_e_sb, r_e_big);
        end else begin
            n_x = r_e_car;
            n_y = $signed(CW'(r_e_yv));
            n_z = r_e_sar;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (en) begin
            o_out_valid <= r_e_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_x    <= n_x;
            o_y    <= n_y;
            o_z    <= n_z;
            o_last <= r_e_last;
        end
    end

endmodule

`default_nettype wire

// File: rtl/revolved_primitive_tessellator_core.sv
// ---------------------------------------------------------------------------
// Revolved primitive tessellator
// Expands one slice request into the triangle-list vertices of a cone,
// cylinder, tube or torus slice, with a configuration register file.
// ---------------------------------------------------------------------------
// The slice sequencer issues one vertex per cycle while the pipe is not stalled;
//   a slice is 6 (cone, torus), 18 (cylinder) or 48 (tube) vertices long.
// The next request is taken while the previous slice's last vertex issues.
// Reset clears the pipe valid bits, the sequencer and loads register defaults.
`default_nettype none

module revolved_primitive_tessellator_core #(
    parameter int ANGLE_BITS       = rpt_pkg::ANGLE_BITS,
    parameter int TABLE_ENTRIES    = rpt_pkg::TABLE_ENTRIES,
    parameter int MAX_SUBDIVISIONS = rpt_pkg::MAX_SUBDIVISIONS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    rpt_in_if.sink           i_in,
    rpt_out_if.source        o_out
);

    localparam int RW = rpt_pkg::RAD_W;
    localparam int IW = rpt_pkg::IDX_W;
    localparam int CN = rpt_pkg::CNT_W;

    // ---- configuration registers
    rpt_pkg::t_shape          r_shape;
    logic [RW-1:0]            r_outer;
    logic [RW-1:0]            r_inner;
    logic [RW-1:0]            r_height;
    logic [CN-1:0]            r_seg_cnt;
    logic [CN-1:0]            r_ring_cnt;
    logic [rpt_pkg::STEP_W-1:0] r_seg_step;
    logic [rpt_pkg::STEP_W-1:0] r_ring_step;

    logic [2:0] reg_idx;
    assign reg_idx = paddr[4:2];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shape     <= rpt_pkg::SHAPE_CONE;
            r_outer     <= 24'd65536;
            r_inner     <= 24'd32768;
            r_height    <= 24'd65536;
            r_seg_cnt   <= 9'd3;
            r_ring_cnt  <= 9'd3;
            r_seg_step  <= 16'd21845;
            r_ring_step <= 16'd21845;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                rpt_pkg::REG_SHAPE:      r_shape     <= rpt_pkg::t_shape'(pwdata[1:0]);
                rpt_pkg::REG_OUTER:      r_outer     <= pwdata[RW-1:0];
                rpt_pkg::REG_INNER:      r_inner     <= pwdata[RW-1:0];
                rpt_pkg::REG_HEIGHT:     r_height    <= pwdata[RW-1:0];
                rpt_pkg::REG_SEG_COUNT:  r_seg_cnt   <= pwdata[CN-1:0];
                rpt_pkg::REG_RING_COUNT: r_ring_cnt  <= pwdata[CN-1:0];
                rpt_pkg::REG_SEG_STEP:   r_seg_step  <= pwdata[15:0];
                rpt_pkg::REG_RING_STEP:  r_ring_step <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // register read-back
    always_comb begin
        case (reg_idx)
            rpt_pkg::REG_SHAPE:      prdata = 32'(r_shape);
            rpt_pkg::REG_OUTER:      prdata = 32'(r_outer);
            rpt_pkg::REG_INNER:      prdata = 32'(r_inner);
            rpt_pkg::REG_HEIGHT:     prdata = 32'(r_height);
            rpt_pkg::REG_SEG_COUNT:  prdata = 32'(r_seg_cnt);
            rpt_pkg::REG_RING_COUNT: prdata = 32'(r_ring_cnt);
            rpt_pkg::REG_SEG_STEP:   prdata = 32'(r_seg_step);
            rpt_pkg::REG_RING_STEP:  prdata = 32'(r_ring_step);
            default:                 prdata = '0;
        endcase
    end

    // ---- effective geometry: minimums, radius swap, tube radius
    logic [RW-1:0] out_c;
    logic [RW-1:0] in_c;
    logic [RW-1:0] h_eff;
    logic [RW-1:0] out_eff;
    logic [RW-1:0] in_eff;
    logic [RW-1:0] rt_eff;
    logic          swap;
    logic [CN-1:0] segs;
    logic [CN-1:0] rings;

    always_comb begin
        out_c   = (r_outer < rpt_pkg::MIN_OUTER) ? rpt_pkg::MIN_OUTER : r_outer;
        in_c    = (r_inner < rpt_pkg::MIN_INNER) ? rpt_pkg::MIN_INNER : r_inner;
        h_eff   = (r_height < rpt_pkg::MIN_HEIGHT) ? rpt_pkg::MIN_HEIGHT : r_height;
        swap    = r_shape[1] && (in_c > out_c);
        out_eff = swap ? in_c : out_c;
        in_eff  = swap ? out_c : in_c;
        rt_eff  = (out_eff - in_eff) >> 1;
        segs    = rpt_pkg::clamp_count(r_seg_cnt, MAX_SUBDIVISIONS);
        rings   = rpt_pkg::clamp_count(r_ring_cnt, MAX_SUBDIVISIONS);
    end

    // ---- index clamping and successor
    logic [IW-1:0] sn;
    logic [IW-1:0] rn;
    logic [IW:0]   sn_inc;
    logic [IW:0]   rn_inc;

    always_comb begin
        sn     = (i_in.segment_index >= segs) ? IW'(segs - 1'b1) : i_in.segment_index;
        rn     = (i_in.ring_index >= rings) ? IW'(rings - 1'b1) : i_in.ring_index;
        sn_inc = {1'b0, sn} + 1'b1;
        rn_inc = {1'b0, rn} + 1'b1;
    end

    // ---- slice sequencer
    logic          r_busy;
    logic [IW-1:0] r_sn;
    logic [IW-1:0] r_sm;
    logic [IW-1:0] r_rn;
    logic [IW-1:0] r_rm;
    logic [2:0]    r_grp;
    logic [2:0]    r_pos;

    logic              req_ready;
    logic              issue;
    logic              slice_end;
    logic              take;
    rpt_pkg::t_point   pt;
    rpt_pkg::t_vtx_req req;

    always_comb begin
        slice_end = (r_pos == 3'd5) && (r_grp == rpt_pkg::last_group(r_shape));
        issue     = r_busy && req_ready;
        i_in.ready = !r_busy || (issue && slice_end);
        take      = i_in.valid && i_in.ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_grp  <= '0;
            r_pos  <= '0;
        end else if (take) begin
            r_busy <= 1'b1;
            r_grp  <= '0;
            r_pos  <= '0;
        end else if (issue) begin
            if (slice_end) begin
                r_busy <= 1'b0;
            end
            if (r_pos == 3'd5) begin
                r_pos <= '0;
                r_grp <= r_grp + 1'b1;
            end else begin
                r_pos <= r_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_sn <= sn;
            r_rn <= rn;
            r_sm <= (sn_inc == {1'b0, segs}) ? '0 : sn_inc[IW-1:0];
            r_rm <= (rn_inc == {1'b0, rings}) ? '0 : rn_inc[IW-1:0];
        end
    end

    // vertex request for the current slice position
    always_comb begin
        pt           = rpt_pkg::point_desc(r_shape, r_grp, r_pos);
        req.torus    = (r_shape == rpt_pkg::SHAPE_TORUS);
        req.last     = slice_end;
        req.seg_idx  = pt.seg_next ? r_sm : r_sn;
        req.ring_idx = pt.ring_next ? r_rm : r_rn;
        case (pt.rsel)
            rpt_pkg::RSEL_OUTER: req.rad = out_eff;
            rpt_pkg::RSEL_INNER: req.rad = in_eff;
            rpt_pkg::RSEL_TUBE:  req.rad = rt_eff;
            default:             req.rad = '0;
        endcase
        req.outer    = out_eff;
        req.yv       = pt.y_top ? h_eff : '0;
    end

    // ---- compute pipeline
    rpt_vertex_pipe #(
        .ANGLE_BITS    (ANGLE_BITS),
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_pipe (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (r_busy),
        .i_req       (req),
        .i_seg_step  (r_seg_step),
        .i_ring_step (r_ring_step),
        .o_req_ready (req_ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_x         (o_out.vertex_x),
        .o_y         (o_out.vertex_y),
        .o_z         (o_out.vertex_z),
        .o_last      (o_out.last_vertex)
    );

endmodule

`default_nettype wire

// File: tb/revolved_primitive_tessellator_core_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Revolved primitive tessellator testbench
// Sends slice requests for each shape under several register settings and
// idle patterns. A built-in predictor works out every vertex and a monitor
// compares each accepted vertex with the oldest one still awaited.
// ---------------------------------------------------------------------------

module revolved_primitive_tessellator_core_tb;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 64;

    typedef struct {
        longint x;
        longint y;
        longint z;
    } t_pt;

    typedef struct packed {
        logic signed [rpt_pkg::COORD_W-1:0] x;
        logic signed [rpt_pkg::COORD_W-1:0] y;
        logic signed [rpt_pkg::COORD_W-1:0] z;
        logic                               last;
    } t_vert;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    rpt_in_if  in_ch ();
    rpt_out_if out_ch ();

    // register shadow
    rpt_pkg::t_shape           cfg_shape;
    logic [rpt_pkg::RAD_W-1:0] cfg_outer;
    logic [rpt_pkg::RAD_W-1:0] cfg_inner;
    logic [rpt_pkg::RAD_W-1:0] cfg_height;
    logic [rpt_pkg::CNT_W-1:0] cfg_seg_count;
    logic [rpt_pkg::CNT_W-1:0] cfg_ring_count;
    logic [15:0]               cfg_seg_step;
    logic [15:0]               cfg_ring_step;

    t_pt   slice_pts[$];
    t_vert vertex_q[$];

    int src_idle_pct;
    int snk_stall_pct;
    int err_count;
    int requests_sent;
    int vertices_seen;
    int reg_writes;
    int quiet_cycles;

    revolved_primitive_tessellator_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    // clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // ---------------------------------------------------------------------
    // Geometry predictor
    // ---------------------------------------------------------------------

    // sine of a 32-bit turn fraction, Q16, Taylor series in Q30
    function automatic longint sine_of_turn(input logic [31:0] t);
        longint unsigned r;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned s;
        longint unsigned v;
        longint unsigned taylor_div[5];
        taylor_div = '{110, 72, 42, 20, 6};
        r = {34'd0, t[29:0]};
        if (t[30]) begin
            r = 64'd1073741824 - r;
        end
        x  = (r * 64'd1686629713) >> 30;
        x2 = (x * x) >> 30;
        s  = 64'd1073741824;
        for (int i = 0; i < 5; i++) begin
            s = 64'd1073741824 - ((x2 * s) >> 30) / taylor_div[i];
        end
        v = ((x * s) >> 30) + 64'd8192;
        v = v >> 14;
        return t[31] ? -longint'(v) : longint'(v);
    endfunction

    // table lookup: 1024 entries, each a 2^22 slice of the turn
    function automatic longint angle_trig(input int unsigned idx, input logic [15:0] step,
                                          input bit want_cos);
        logic [15:0] phase;
        logic [31:0] t;
        phase = 16'(idx * step);
        t     = {phase[15:6], 22'd0};
        if (want_cos) begin
            t = t + 32'h4000_0000;
        end
        return sine_of_turn(t);
    endfunction

    // Q16 product, half away from zero
    function automatic longint q16_mul(input longint a, input longint b);
        longint p;
        p = a * b;
        if (p < 0) begin
            return -(((-p) + 32768) >>> 16);
        end
        return (p + 32768) >>> 16;
    endfunction

    function automatic int unsigned count_clamp(input logic [rpt_pkg::CNT_W-1:0] c);
        if (c < 3) return 3;
        if (c > rpt_pkg::MAX_SUBDIVISIONS) return rpt_pkg::MAX_SUBDIVISIONS;
        return c;
    endfunction

    function automatic t_pt rim_point(input int unsigned idx, input longint r,
                                      input longint y);
        t_pt p;
        p.x = q16_mul(angle_trig(idx, cfg_seg_step, 1'b1), r);
        p.y = y;
        p.z = q16_mul(angle_trig(idx, cfg_seg_step, 1'b0), r);
        return p;
    endfunction

    function automatic t_pt torus_point(input int unsigned seg, input int unsigned ring,
                                        input longint outer, input longint rt);
        t_pt    p;
        longint big;
        big = outer + q16_mul(angle_trig(seg, cfg_seg_step, 1'b1), rt);
        p.x = q16_mul(angle_trig(ring, cfg_ring_step, 1'b1), big);
        p.y = q16_mul(angle_trig(seg, cfg_seg_step, 1'b0), rt);
        p.z = -q16_mul(angle_trig(ring, cfg_ring_step, 1'b0), big);
        return p;
    endfunction

    // append one point to the slice being built
    function automatic void keep_point(input t_pt p);
        slice_pts = {slice_pts, p};
    endfunction

    // append one vertex to the awaited list
    function automatic void await_vertex(input t_vert v);
        vertex_q = {vertex_q, v};
    endfunction

    function automatic void add_tri(input t_pt a, input t_pt b, input t_pt c);
        keep_point(a);
        keep_point(b);
        keep_point(c);
    endfunction

    // quad A,B,C,D goes out as A,B,C then C,B,D
    function automatic void add_quad(input t_pt a, input t_pt b, input t_pt c, input t_pt d);
        add_tri(a, b, c);
        add_tri(c, b, d);
    endfunction

    // expand one slice request into the vertices it should produce
    function automatic void predict_slice(input logic [8:0] seg_in, input logic [8:0] ring_in);
        int unsigned segs;
        int unsigned rings;
        int unsigned sn;
        int unsigned sm;
        int unsigned rn;
        int unsigned rm;
        longint      outer;
        longint      inner;
        longint      h;
        longint      swap_tmp;
        longint      rt;
        t_pt         org;
        t_pt         top;
        t_pt         obn, obm, ibn, ibm, otn, otm, itn, itm;
        t_vert       v;
        segs  = count_clamp(cfg_seg_count);
        rings = count_clamp(cfg_ring_count);
        sn    = (seg_in >= segs) ? segs - 1 : seg_in;
        rn    = (ring_in >= rings) ? rings - 1 : ring_in;
        sm    = (sn + 1 == segs) ? 0 : sn + 1;
        rm    = (rn + 1 == rings) ? 0 : rn + 1;
        outer = (cfg_outer < rpt_pkg::MIN_OUTER) ? rpt_pkg::MIN_OUTER : cfg_outer;
        inner = (cfg_inner < rpt_pkg::MIN_INNER) ? rpt_pkg::MIN_INNER : cfg_inner;
        h     = (cfg_height < rpt_pkg::MIN_HEIGHT) ? rpt_pkg::MIN_HEIGHT : cfg_height;
        org   = '{0, 0, 0};
        top   = '{0, h, 0};
        // inverted radii on tube and torus
        if ((cfg_shape == rpt_pkg::SHAPE_TUBE || cfg_shape == rpt_pkg::SHAPE_TORUS) &&
            inner > outer) begin
            swap_tmp = inner;
            inner    = outer;
            outer    = swap_tmp;
        end
        slice_pts.delete();
        obn = rim_point(sn, outer, 0);
        obm = rim_point(sm, outer, 0);
        otn = rim_point(sn, outer, h);
        otm = rim_point(sm, outer, h);
        ibn = rim_point(sn, inner, 0);
        ibm = rim_point(sm, inner, 0);
        itn = rim_point(sn, inner, h);
        itm = rim_point(sm, inner, h);
        case (cfg_shape)
            rpt_pkg::SHAPE_CONE: begin
                add_tri(org, obn, obm);
                add_tri(top, obm, obn);
            end
            rpt_pkg::SHAPE_CYL: begin
                add_quad(otn, otm, obn, obm);
                add_quad(obn, obm, otn, otm);
                add_tri(org, obn, obm);
                add_tri(top, otm, otn);
            end
            rpt_pkg::SHAPE_TUBE: begin
                add_quad(obn, obm, ibn, ibm);
                add_quad(ibn, ibm, obn, obm);
                add_quad(otn, otm, itn, itm);
                add_quad(itn, itm, otn, otm);
                add_quad(obn, obm, otn, otm);
                add_quad(otn, otm, obn, obm);
                add_quad(ibn, ibm, itn, itm);
                add_quad(itn, itm, ibn, ibm);
            end
            default: begin
                rt = (outer - inner) >>> 1;
                add_quad(torus_point(sn, rn, outer, rt), torus_point(sn, rm, outer, rt),
                         torus_point(sm, rn, outer, rt), torus_point(sm, rm, outer, rt));
            end
        endcase
        foreach (slice_pts[i]) begin
            v.x    = rpt_pkg::COORD_W'(slice_pts[i].x);
            v.y    = rpt_pkg::COORD_W'(slice_pts[i].y);
            v.z    = rpt_pkg::COORD_W'(slice_pts[i].z);
            v.last = (i == slice_pts.size() - 1);
            await_vertex(v);
        end
    endfunction

    // ---------------------------------------------------------------------
    // Vertex checker, receiver stalls and watchdog
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_vert exp_v;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            vertices_seen++;
            if (vertex_q.size() == 0) begin
                $error("unexpected vertex x=%0d y=%0d z=%0d", out_ch.vertex_x,
                       out_ch.vertex_y, out_ch.vertex_z);
                err_count++;
            end else begin
                exp_v = vertex_q.pop_front();
                if (out_ch.vertex_x !== exp_v.x) begin
                    $error("vertex_x expected %0d got %0d", exp_v.x, out_ch.vertex_x);
                    err_count++;
                end
                if (out_ch.vertex_y !== exp_v.y) begin
                    $error("vertex_y expected %0d got %0d", exp_v.y, out_ch.vertex_y);
                    err_count++;
                end
                if (out_ch.vertex_z !== exp_v.z) begin
                    $error("vertex_z expected %0d got %0d", exp_v.z, out_ch.vertex_z);
                    err_count++;
                end
                if (out_ch.last_vertex !== exp_v.last) begin
                    $error("last_vertex expected %0d got %0d", exp_v.last,
                           out_ch.last_vertex);
                    err_count++;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------------
    task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        reg_writes++;
        case (idx)
            rpt_pkg::REG_SHAPE:      cfg_shape      = rpt_pkg::t_shape'(value[1:0]);
            rpt_pkg::REG_OUTER:      cfg_outer      = value[rpt_pkg::RAD_W-1:0];
            rpt_pkg::REG_INNER:      cfg_inner      = value[rpt_pkg::RAD_W-1:0];
            rpt_pkg::REG_HEIGHT:     cfg_height     = value[rpt_pkg::RAD_W-1:0];
            rpt_pkg::REG_SEG_COUNT:  cfg_seg_count  = value[rpt_pkg::CNT_W-1:0];
            rpt_pkg::REG_RING_COUNT: cfg_ring_count = value[rpt_pkg::CNT_W-1:0];
            rpt_pkg::REG_SEG_STEP:   cfg_seg_step   = value[15:0];
            rpt_pkg::REG_RING_STEP:  cfg_ring_step  = value[15:0];
            default: ;
        endcase
    endtask

    // one slice request, with random sender gaps ahead of it
    task automatic send_slice(input logic [8:0] seg, input logic [8:0] ring);
        @(negedge i_clk);
        if ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < src_idle_pct);
        end
        in_ch.valid         <= 1'b1;
        in_ch.segment_index <= seg;
        in_ch.ring_index    <= ring;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_slice(seg, ring);
        requests_sent++;
    endtask

    // wait for every awaited vertex, then let the pipe empty
    task automatic settle();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (vertex_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_config(input rpt_pkg::t_shape shape, input logic [23:0] outer,
                               input logic [23:0] inner, input logic [23:0] height,
                               input logic [8:0] segc, input logic [8:0] ringc,
                               input logic [15:0] sstep, input logic [15:0] rstep);
        settle();
        reg_write(rpt_pkg::REG_SHAPE, 32'(shape));
        reg_write(rpt_pkg::REG_OUTER, 32'(outer));
        reg_write(rpt_pkg::REG_INNER, 32'(inner));
        reg_write(rpt_pkg::REG_HEIGHT, 32'(height));
        reg_write(rpt_pkg::REG_SEG_COUNT, 32'(segc));
        reg_write(rpt_pkg::REG_RING_COUNT, 32'(ringc));
        reg_write(rpt_pkg::REG_SEG_STEP, 32'(sstep));
        reg_write(rpt_pkg::REG_RING_STEP, 32'(rstep));
    endtask

    function automatic logic [23:0] pick_length();
        case ($urandom_range(9))
            0:       return 24'd0;
            1:       return 24'hFFFFFF;
            2:       return 24'($urandom_range(0, 700));
            default: return 24'($urandom_range(1000, 24'h3FFFFF));
        endcase
    endfunction

    function automatic logic [8:0] pick_count();
        case ($urandom_range(5))
            0:       return 9'($urandom_range(0, 2));
            1:       return 9'($urandom_range(361, 511));
            default: return 9'($urandom_range(3, 40));
        endcase
    endfunction

    function automatic logic [15:0] pick_step(input logic [8:0] c);
        if ($urandom_range(3) == 0) return 16'($urandom);
        return 16'(65536 / count_clamp(c));
    endfunction

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------
    task automatic test_cone_limits();
        // zero radius and count below minimum, oversized index
        load_config(rpt_pkg::SHAPE_CONE, 24'd0, 24'd0, 24'hFFFFFF, 9'd0, 9'd0,
                    16'd21845, 16'd0);
        send_slice(9'd0, 9'd0);
        send_slice(9'd2, 9'd511);
        send_slice(9'd511, 9'd0);
        load_config(rpt_pkg::SHAPE_CONE, 24'hFFFFFF, 24'd328, 24'd0, 9'd360, 9'd3,
                    16'hFFFF, 16'hFFFF);
        send_slice(9'd359, 9'h1FF);
        send_slice(9'd100, 9'd0);
    endtask

    task automatic test_cylinder();
        // count above maximum, step disagreeing with the count
        load_config(rpt_pkg::SHAPE_CYL, 24'hFFFFFF, 24'd0, 24'd0, 9'd511, 9'd511,
                    16'hFFFF, 16'd7);
        send_slice(9'd0, 9'd0);
        send_slice(9'd359, 9'd5);
        send_slice(9'd511, 9'd511);
        send_slice(9'd256, 9'd0);
    endtask

    task automatic test_tube();
        // inner larger than outer: radii swap
        load_config(rpt_pkg::SHAPE_TUBE, 24'd1000, 24'hFFFFFF, 24'h20000, 9'd360, 9'd3,
                    16'd182, 16'd1);
        send_slice(9'd0, 9'd0);
        send_slice(9'd180, 9'd0);
        send_slice(9'd359, 9'd0);
        load_config(rpt_pkg::SHAPE_TUBE, 24'h30000, 24'd0, 24'd655, 9'd4, 9'd3,
                    16'd16384, 16'd1);
        send_slice(9'd3, 9'd0);
        send_slice(9'd4, 9'd0);
    endtask

    task automatic test_torus();
        load_config(rpt_pkg::SHAPE_TORUS, 24'h30000, 24'h10000, 24'd0, 9'd8, 9'd2,
                    16'd8192, 16'd0);
        send_slice(9'd0, 9'd0);
        send_slice(9'd7, 9'd2);
        send_slice(9'd3, 9'd511);
        // inverted radii and ring step at its top value
        load_config(rpt_pkg::SHAPE_TORUS, 24'd0, 24'hFFFFFF, 24'd1, 9'd360, 9'd360,
                    16'd182, 16'hFFFF);
        send_slice(9'd359, 9'd359);
        send_slice(9'd0, 9'd180);
        send_slice(9'd511, 9'd0);
    endtask

    task automatic test_random_slices(input int n_items, input int idle_pct,
                                      input int stall_pct);
        rpt_pkg::t_shape shape;
        logic [8:0]      segc;
        logic [8:0]      ringc;
        logic [8:0]      seg;
        logic [8:0]      ring;
        int unsigned     segs;
        int unsigned     rings;
        src_idle_pct  = idle_pct;
        snk_stall_pct = stall_pct;
        for (int i = 0; i < n_items; i++) begin
            if (i % 28 == 0) begin
                shape = rpt_pkg::t_shape'($urandom_range(3));
                segc  = pick_count();
                ringc = pick_count();
                load_config(shape, pick_length(), pick_length(), pick_length(), segc, ringc,
                            pick_step(segc), pick_step(ringc));
                segs  = count_clamp(segc);
                rings = count_clamp(ringc);
            end
            seg  = ($urandom_range(9) == 0) ? 9'($urandom) : 9'($urandom_range(0, segs - 1));
            ring = ($urandom_range(9) == 0) ? 9'($urandom) : 9'($urandom_range(0, rings - 1));
            send_slice(seg, ring);
        end
    endtask

    initial begin
        i_rst_n             = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        in_ch.valid         = 1'b0;
        in_ch.segment_index = '0;
        in_ch.ring_index    = '0;
        out_ch.ready        = 1'b1;
        src_idle_pct        = 0;
        snk_stall_pct       = 0;
        err_count           = 0;
        requests_sent       = 0;
        vertices_seen       = 0;
        reg_writes          = 0;
        quiet_cycles        = 0;
        cfg_shape           = rpt_pkg::SHAPE_CONE;
        cfg_outer           = 24'd65536;
        cfg_inner           = 24'd32768;
        cfg_height          = 24'd65536;
        cfg_seg_count       = 9'd3;
        cfg_ring_count      = 9'd3;
        cfg_seg_step        = 16'd21845;
        cfg_ring_step       = 16'd21845;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // default registers first
        send_slice(9'd1, 9'd1);
        test_cone_limits();
        test_cylinder();
        test_tube();
        test_torus();
        test_random_slices(112, 0, 0);
        test_random_slices(112, 52, 0);
        test_random_slices(112, 0, 52);
        test_random_slices(112, 8, 8);
        settle();

        $display("Covered %0d slice requests over all four shapes, %0d vertices checked,",
                 requests_sent, vertices_seen);
        $display("%0d register writes including clamped and inverted settings", reg_writes);
        if (err_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/rpt_pkg.sv
rtl/rpt_if.sv
rtl/rpt_vertex_pipe.sv
rtl/revolved_primitive_tessellator_core.sv
tb/revolved_primitive_tessellator_core_tb.sv
